// ===== hdl/mandelbrot_escape_time_macros.svh =====
// assertion macros shared by the escape-time block
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define MBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define MBT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mbt_pkg.sv =====
// shared types and constants for the escape-time block
package mbt_pkg;

  localparam int unsigned PT_W        = 32;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned MUL_DIGIT_W = 16;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_XX,
    ST_YY,
    ST_XY,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             in_set;
  } res_t;

endpackage

// ===== hdl/mbt_mul.sv =====
// digit-serial unsigned multiplier, one 16-bit digit of b per cycle
module mbt_mul #(
  parameter int unsigned A_W = 29
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [A_W-1:0]   a,
  input  logic [A_W-1:0]   b,
  output logic             done,
  output logic [2*A_W-1:0] product
);

  localparam int unsigned D     = mbt_pkg::MUL_DIGIT_W;
  localparam int unsigned NCH   = (A_W + D - 1) / D;
  localparam int unsigned B_W   = NCH * D;
  localparam int unsigned ACC_W = A_W + B_W;
  localparam int unsigned LEFT_W = $clog2(NCH + 1);

  logic [A_W-1:0]    a_r;
  logic [B_W-1:0]    b_r;
  logic [ACC_W-1:0]  acc;
  logic [LEFT_W-1:0] left;
  logic              busy;
  logic [A_W+D-1:0]  pp;

  assign pp = a_r * b_r[B_W-1 -: D];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && left == LEFT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= B_W'(b);
      acc  <= '0;
      left <= LEFT_W'(NCH);
    end else if (busy) begin
      acc  <= (acc << D) + ACC_W'(pp);
      b_r  <= b_r << D;
      left <= left - 1'b1;
    end
  end

  assign product = acc[2*A_W-1:0];

endmodule

// ===== hdl/mbt_core.sv =====
// iteration sequencer and datapath around the shared multiplier
`include "mandelbrot_escape_time_macros.svh"

module mbt_core #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [mbt_pkg::PT_W-1:0]  cx_in,
  input  logic signed [mbt_pkg::PT_W-1:0]  cy_in,
  input  logic [mbt_pkg::CNT_W-1:0]        limit,
  output logic                             idle,
  output logic                             res_valid,
  input  logic                             res_ready,
  output mbt_pkg::res_t                    res
);

  localparam int unsigned ZW = FRAC_BITS + 8;
  localparam int unsigned MW = FRAC_BITS + 1;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned SW = (ZW > 33) ? ZW : 33;

  mbt_pkg::state_t state, state_next;

  logic signed [ZW-1:0]            x, y;
  logic signed [mbt_pkg::PT_W-1:0] cx, cy;
  logic [mbt_pkg::CNT_W-1:0]       count;
  logic [MW-1:0]                   ax_r, ay_r;
  logic                            neg_r;
  logic [PW-1:0]                   sxx, syy, pxy;

  logic [ZW-1:0]                   ax_full, ay_full;
  logic                            big;
  logic [PW:0]                     esc_sum;
  logic                            escape;
  logic signed [PW:0]              diff, pxy_s;
  logic signed [FRAC_BITS+2:0]     nxs;
  logic signed [FRAC_BITS+3:0]     nys;
  logic signed [SW-1:0]            nx_sum, ny_sum;
  logic [ZW-1:0]                   nx, ny;
  logic                            fixed;

  logic                            mul_start, mul_done;
  logic [MW-1:0]                   mul_a, mul_b;
  logic [PW-1:0]                   mul_prod;

  function automatic logic [ZW-1:0] sat(input logic [SW-1:0] v);
    logic hi_ok;
    hi_ok = (v[SW-1:ZW-1] == {(SW-ZW+1){v[SW-1]}});
    if (hi_ok) begin
      sat = v[ZW-1:0];
    end else if (v[SW-1]) begin
      sat = {1'b1, {(ZW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(ZW-1){1'b1}}};
    end
  endfunction

  mbt_mul #(.A_W(MW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  // magnitudes of z and the early escape on either part reaching 2
  assign ax_full = x[ZW-1] ? (~x + 1'b1) : x;
  assign ay_full = y[ZW-1] ? (~y + 1'b1) : y;
  assign big     = (|ax_full[ZW-1:MW]) || (|ay_full[ZW-1:MW]);

  // |z|^2 >= 4 shows as the carry out of the square sum
  assign esc_sum = {1'b0, sxx} + {1'b0, mul_prod};
  assign escape  = esc_sum[PW];

  assign diff   = $signed({1'b0, sxx}) - $signed({1'b0, syy});
  assign pxy_s  = neg_r ? -$signed({1'b0, pxy}) : $signed({1'b0, pxy});
  assign nxs    = diff[PW:FRAC_BITS];
  assign nys    = pxy_s[PW:FRAC_BITS-1];
  assign nx_sum = SW'(nxs) + SW'(cx);
  assign ny_sum = SW'(nys) + SW'(cy);
  assign nx     = sat(nx_sum);
  assign ny     = sat(ny_sum);
  assign fixed  = (nx == x) && (ny == y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = ax_r;
    mul_b      = ay_r;
    case (state)
      mbt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = mbt_pkg::ST_CHECK;
        end
      end
      mbt_pkg::ST_CHECK: begin
        if (count >= limit || big) begin
          state_next = mbt_pkg::ST_DONE;
        end else begin
          mul_start  = 1'b1;
          mul_a      = ax_full[MW-1:0];
          mul_b      = ax_full[MW-1:0];
          state_next = mbt_pkg::ST_XX;
        end
      end
      mbt_pkg::ST_XX: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = ay_r;
          mul_b      = ay_r;
          state_next = mbt_pkg::ST_YY;
        end
      end
      mbt_pkg::ST_YY: begin
        if (mul_done) begin
          if (escape) begin
            state_next = mbt_pkg::ST_DONE;
          end else begin
            mul_start  = 1'b1;
            state_next = mbt_pkg::ST_XY;
          end
        end
      end
      mbt_pkg::ST_XY: begin
        if (mul_done) begin
          state_next = mbt_pkg::ST_UPD;
        end
      end
      mbt_pkg::ST_UPD: begin
        state_next = fixed ? mbt_pkg::ST_DONE : mbt_pkg::ST_CHECK;
      end
      mbt_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = mbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      mbt_pkg::ST_IDLE: begin
        if (start) begin
          x     <= '0;
          y     <= '0;
          count <= '0;
          cx    <= cx_in;
          cy    <= cy_in;
        end
      end
      mbt_pkg::ST_CHECK: begin
        ax_r  <= ax_full[MW-1:0];
        ay_r  <= ay_full[MW-1:0];
        neg_r <= x[ZW-1] ^ y[ZW-1];
      end
      mbt_pkg::ST_XX: begin
        if (mul_done) begin
          sxx <= mul_prod;
        end
      end
      mbt_pkg::ST_YY: begin
        if (mul_done) begin
          syy <= mul_prod;
        end
      end
      mbt_pkg::ST_XY: begin
        if (mul_done) begin
          pxy <= mul_prod;
        end
      end
      mbt_pkg::ST_UPD: begin
        if (fixed) begin
          count <= limit;
        end else begin
          x     <= nx;
          y     <= ny;
          count <= count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign idle       = (state == mbt_pkg::ST_IDLE);
  assign res_valid  = (state == mbt_pkg::ST_DONE);
  assign res.count  = count;
  assign res.in_set = (count == limit);

  `MBT_ASSERT_IMP(a_mul_done_waited, mul_done, state == mbt_pkg::ST_XX || state == mbt_pkg::ST_YY || state == mbt_pkg::ST_XY, "multiplier result with no product pending")
  `MBT_ASSERT_NXT(a_count_step, state == mbt_pkg::ST_UPD && !fixed, state == mbt_pkg::ST_CHECK && count == mbt_pkg::CNT_W'($past(count) + 1'b1), "iteration count did not advance by one")
  `MBT_ASSERT_NXT(a_fixed_point, state == mbt_pkg::ST_UPD && fixed, state == mbt_pkg::ST_DONE && count == $past(limit), "fixed point did not jump to the limit")
  `MBT_ASSERT_NXT(a_result_held, res_valid && !res_ready, res_valid && $stable(count), "pending result changed before transfer")

endmodule

// ===== hdl/mandelbrot_escape_time.sv =====
// escape-time top level: stream ports, limit register and output register
// iterates z = z^2 + c until the limit, an escape by |z|^2 >= 4 or a fixed point
// each square or product is taken over d = ceil((FRAC_BITS + 1) / 16) multiplier digits; d = 2 at FRAC_BITS = 28
// one point at a time: s_axis_tready is high only while no point is being iterated
// a finished result waits in the output register while the next point is taken
// rst (synchronous) empties the output register and sets iteration_limit to 1000
module mandelbrot_escape_time #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // iteration_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // point_real [31:0], point_imag [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // iteration_count [15:0]
  output logic        m_axis_tuser    // inside_set [0]
);

  logic [mbt_pkg::CNT_W-1:0] limit;
  logic                      core_idle;
  logic                      res_valid;
  logic                      res_ready;
  mbt_pkg::res_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= mbt_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  assign s_axis_tready = core_idle;
  assign res_ready     = !m_axis_tvalid || m_axis_tready;

  mbt_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (s_axis_tvalid && s_axis_tready),
    .cx_in     ($signed(s_axis_tdata[31:0])),
    .cy_in     ($signed(s_axis_tdata[63:32])),
    .limit     (limit),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register, which can be refilled in the cycle its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= res.count;
      m_axis_tuser <= res.in_set;
    end
  end

endmodule
